### hw/rtl/iqws_pkg.sv
package iqws_pkg;

    // Operation codes carried by an input beat
    typedef enum logic [1:0] {
        OP_DISPATCH = 2'd0,
        OP_WAKEUP   = 2'd1,
        OP_SELECT   = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int UNIT_W   = 2;
    localparam int UNIT_CNT = 3;

    // Token that walks the cell row, one cell per cycle
    typedef struct packed {
        logic active;
        logic found;
    } t_scan;

    // Commands broadcast from the sequencer to every cell
    typedef struct packed {
        logic wake;
        logic commit;
        logic alloc_mode;
    } t_cell_cmd;

endpackage

### hw/rtl/iqws_cell.sv
module iqws_cell #(
    parameter int TAG_W    = 6,
    parameter int SEQ_BITS = 16,
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  iqws_pkg::t_cell_cmd     i_cmd,
    input  logic [TAG_W-1:0]        i_wake_tag,
    input  logic [IDX_W-1:0]        i_commit_idx,
    // entry written on dispatch
    input  logic [TAG_W-1:0]        i_tag_a,
    input  logic                    i_rdy_a,
    input  logic [TAG_W-1:0]        i_tag_b,
    input  logic                    i_rdy_b,
    input  logic [TAG_W-1:0]        i_dest,
    input  logic [iqws_pkg::UNIT_W-1:0] i_unit,
    input  logic [SEQ_BITS-1:0]     i_seq,
    // scan token and best candidate from the previous cell
    input  iqws_pkg::t_scan         i_scan,
    input  logic [SEQ_BITS-1:0]     i_best_seq,
    input  logic [IDX_W-1:0]        i_best_idx,
    input  logic [TAG_W-1:0]        i_best_dest,
    input  logic [iqws_pkg::UNIT_W-1:0] i_best_unit,
    // scan token and best candidate to the next cell
    output iqws_pkg::t_scan         o_scan,
    output logic [SEQ_BITS-1:0]     o_best_seq,
    output logic [IDX_W-1:0]        o_best_idx,
    output logic [TAG_W-1:0]        o_best_dest,
    output logic [iqws_pkg::UNIT_W-1:0] o_best_unit
);
    import iqws_pkg::*;

    logic                r_valid;
    logic [TAG_W-1:0]    r_tag_a;
    logic                r_rdy_a;
    logic [TAG_W-1:0]    r_tag_b;
    logic                r_rdy_b;
    logic [TAG_W-1:0]    r_dest;
    logic [UNIT_W-1:0]   r_unit;
    logic [SEQ_BITS-1:0] r_seq;

    t_scan               r_scan;
    logic [SEQ_BITS-1:0] r_best_seq;
    logic [IDX_W-1:0]    r_best_idx;
    logic [TAG_W-1:0]    r_best_dest;
    logic [UNIT_W-1:0]   r_best_unit;

    logic take;
    logic cand;
    logic better;
    logic commit_hit;

    // Claim this slot or win the oldest-ready compare as the token passes
    always_comb begin
        take       = i_scan.active && i_cmd.alloc_mode && !r_valid && !i_scan.found;
        cand       = r_valid && r_rdy_a && r_rdy_b;
        better     = i_scan.active && !i_cmd.alloc_mode && cand &&
                     (!i_scan.found || (r_seq < i_best_seq));
        commit_hit = i_cmd.commit && (i_commit_idx == IDX_W'(CELL_IDX));
    end

    // Valid bit: set on claim, drop on issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (commit_hit) begin
            r_valid <= 1'b0;
        end
    end

    // Entry record: write on claim, set ready bits on matching wakeup
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tag_a <= i_tag_a;
            r_rdy_a <= i_rdy_a;
            r_tag_b <= i_tag_b;
            r_rdy_b <= i_rdy_b;
            r_dest  <= i_dest;
            r_unit  <= i_unit;
            r_seq   <= i_seq;
        end else if (i_cmd.wake && r_valid) begin
            if (r_tag_a == i_wake_tag) begin
                r_rdy_a <= 1'b1;
            end
            if (r_tag_b == i_wake_tag) begin
                r_rdy_b <= 1'b1;
            end
        end
    end

    // Advance the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan.active <= i_scan.active;
            r_scan.found  <= i_scan.found || take || better;
        end
    end

    // Hand on the best candidate so far
    always_ff @(posedge i_clk) begin
        if (better) begin
            r_best_seq  <= r_seq;
            r_best_idx  <= IDX_W'(CELL_IDX);
            r_best_dest <= r_dest;
            r_best_unit <= r_unit;
        end else begin
            r_best_seq  <= i_best_seq;
            r_best_idx  <= i_best_idx;
            r_best_dest <= i_best_dest;
            r_best_unit <= i_best_unit;
        end
    end

    assign o_scan      = r_scan;
    assign o_best_seq  = r_best_seq;
    assign o_best_idx  = r_best_idx;
    assign o_best_dest = r_best_dest;
    assign o_best_unit = r_best_unit;

endmodule

### hw/rtl/issue_queue_wakeup_select.sv
// Issue queue with tag wakeup and oldest-ready select.
// Command channel: a beat is taken at a rising edge with start high and busy
// low. i_op picks dispatch, wakeup or select; the other fields carry the
// dispatched entry, the completed tag (i_dest_tag on wakeup) or the mask of
// free unit classes (select).
// Result channel: every beat gives one result, shown for exactly one cycle
// with o_strobe high. The receiver cannot stall; it must take the result.
// Operation flow:
//   wakeup and unused op: strobe in the cycle after the beat, busy stays low,
//   so a beat may follow in every cycle.
//   dispatch and select: a token walks the row of QUEUE_DEPTH entry cells,
//   one cell per cycle, to find the lowest free slot or the oldest ready
//   entry. busy is high from the beat until the strobe, which comes once the
//   token has left the last cell; no new beat is taken during the scan.
// o_free_slots gives the number of empty slots after the beat.
// Reset (synchronous, active low) empties the queue; no result is pending.
module issue_queue_wakeup_select #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_COUNT   = 64,
    parameter int SEQ_BITS    = 16,
    localparam int TAG_W      = $clog2(TAG_COUNT),
    localparam int FREE_W     = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [iqws_pkg::OP_W-1:0]   i_op,
    input  logic [TAG_W-1:0]            i_src_a_tag,
    input  logic                        i_src_a_present,
    input  logic                        i_src_a_ready,
    input  logic [TAG_W-1:0]            i_src_b_tag,
    input  logic                        i_src_b_present,
    input  logic                        i_src_b_ready,
    input  logic [TAG_W-1:0]            i_dest_tag,
    input  logic [iqws_pkg::UNIT_W-1:0] i_unit_type,
    input  logic [SEQ_BITS-1:0]         i_age_seq,
    input  logic [iqws_pkg::UNIT_CNT-1:0] i_unit_free_mask,
    output logic                        o_strobe,
    output logic                        o_issued,
    output logic [TAG_W-1:0]            o_issued_dest,
    output logic [iqws_pkg::UNIT_W-1:0] o_issued_unit,
    output logic [SEQ_BITS-1:0]         o_issued_seq,
    output logic                        o_accepted,
    output logic [FREE_W-1:0]           o_free_slots
);
    import iqws_pkg::*;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int MASK_W = 2 ** UNIT_W;

    t_state              r_state;
    t_state              n_state;
    t_op                 r_op;
    logic                r_launch;
    logic                n_launch;
    logic [FREE_W-1:0]   r_free;
    logic [FREE_W-1:0]   n_free;

    // latched command fields
    logic [TAG_W-1:0]    r_tag_a;
    logic                r_rdy_a;
    logic [TAG_W-1:0]    r_tag_b;
    logic                r_rdy_b;
    logic [TAG_W-1:0]    r_dest;
    logic [UNIT_W-1:0]   r_unit;
    logic [SEQ_BITS-1:0] r_seq;
    logic [UNIT_CNT-1:0] r_mask;

    // result registers
    logic                r_strobe;
    logic                n_strobe;
    logic                r_issued;
    logic                n_issued;
    logic [TAG_W-1:0]    r_issued_dest;
    logic [TAG_W-1:0]    n_issued_dest;
    logic [UNIT_W-1:0]   r_issued_unit;
    logic [UNIT_W-1:0]   n_issued_unit;
    logic [SEQ_BITS-1:0] r_issued_seq;
    logic [SEQ_BITS-1:0] n_issued_seq;
    logic                r_accepted;
    logic                n_accepted;

    logic                accept;
    t_op                 in_op;
    t_cell_cmd           cmd;
    logic [MASK_W-1:0]   mask_ext;
    logic                issue_ok;

    // cell row links
    t_scan               scan      [QUEUE_DEPTH+1];
    logic [SEQ_BITS-1:0] best_seq  [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]    best_idx  [QUEUE_DEPTH+1];
    logic [TAG_W-1:0]    best_dest [QUEUE_DEPTH+1];
    logic [UNIT_W-1:0]   best_unit [QUEUE_DEPTH+1];

    assign accept = start && (r_state == ST_IDLE);
    assign in_op  = t_op'(i_op);
    assign busy   = (r_state != ST_IDLE);

    // Launch the token into the first cell
    assign scan[0].active = r_launch;
    assign scan[0].found  = 1'b0;
    assign best_seq[0]    = '0;
    assign best_idx[0]    = '0;
    assign best_dest[0]   = '0;
    assign best_unit[0]   = '0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            iqws_cell #(
                .TAG_W    (TAG_W),
                .SEQ_BITS (SEQ_BITS),
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (cmd),
                .i_wake_tag   (i_dest_tag),
                .i_commit_idx (best_idx[QUEUE_DEPTH]),
                .i_tag_a      (r_tag_a),
                .i_rdy_a      (r_rdy_a),
                .i_tag_b      (r_tag_b),
                .i_rdy_b      (r_rdy_b),
                .i_dest       (r_dest),
                .i_unit       (r_unit),
                .i_seq        (r_seq),
                .i_scan       (scan[g]),
                .i_best_seq   (best_seq[g]),
                .i_best_idx   (best_idx[g]),
                .i_best_dest  (best_dest[g]),
                .i_best_unit  (best_unit[g]),
                .o_scan       (scan[g+1]),
                .o_best_seq   (best_seq[g+1]),
                .o_best_idx   (best_idx[g+1]),
                .o_best_dest  (best_dest[g+1]),
                .o_best_unit  (best_unit[g+1])
            );
        end
    endgenerate

    // Oldest ready entry may issue only if its unit class is free
    assign mask_ext = {{(MASK_W - UNIT_CNT){1'b0}}, r_mask};
    assign issue_ok = scan[QUEUE_DEPTH].found && mask_ext[best_unit[QUEUE_DEPTH]];

    // Next state, cell commands and result
    always_comb begin
        n_state        = r_state;
        n_launch       = 1'b0;
        n_free         = r_free;
        n_strobe       = 1'b0;
        n_issued       = 1'b0;
        n_issued_dest  = '0;
        n_issued_unit  = '0;
        n_issued_seq   = '0;
        n_accepted     = 1'b0;
        cmd.wake       = 1'b0;
        cmd.commit     = 1'b0;
        cmd.alloc_mode = (r_op == OP_DISPATCH);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_DISPATCH, OP_SELECT: begin
                            n_state  = ST_SCAN;
                            n_launch = 1'b1;
                        end
                        OP_WAKEUP: begin
                            cmd.wake = 1'b1;
                            n_strobe = 1'b1;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan[QUEUE_DEPTH].active) begin
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                    if (r_op == OP_DISPATCH) begin
                        n_accepted = scan[QUEUE_DEPTH].found;
                        if (scan[QUEUE_DEPTH].found) begin
                            n_free = r_free - FREE_W'(1);
                        end
                    end else if (issue_ok) begin
                        cmd.commit    = 1'b1;
                        n_issued      = 1'b1;
                        n_issued_dest = best_dest[QUEUE_DEPTH];
                        n_issued_unit = best_unit[QUEUE_DEPTH];
                        n_issued_seq  = best_seq[QUEUE_DEPTH];
                        n_free        = r_free + FREE_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
            r_free   <= FREE_W'(QUEUE_DEPTH);
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_free   <= n_free;
            r_strobe <= n_strobe;
        end
    end

    // Hold the command fields for the scan
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= in_op;
            r_tag_a <= i_src_a_tag;
            r_rdy_a <= !i_src_a_present || i_src_a_ready;
            r_tag_b <= i_src_b_tag;
            r_rdy_b <= !i_src_b_present || i_src_b_ready;
            r_dest  <= i_dest_tag;
            r_unit  <= i_unit_type;
            r_seq   <= i_age_seq;
            r_mask  <= i_unit_free_mask;
        end
    end

    // Result beat payload
    always_ff @(posedge i_clk) begin
        r_issued      <= n_issued;
        r_issued_dest <= n_issued_dest;
        r_issued_unit <= n_issued_unit;
        r_issued_seq  <= n_issued_seq;
        r_accepted    <= n_accepted;
    end

    assign o_strobe      = r_strobe;
    assign o_issued      = r_issued;
    assign o_issued_dest = r_issued_dest;
    assign o_issued_unit = r_issued_unit;
    assign o_issued_seq  = r_issued_seq;
    assign o_accepted    = r_accepted;
    assign o_free_slots  = r_free;

endmodule

### tb/sv/tb.sv
module tb;

    import iqws_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TAG_COUNT    = 64;
    localparam int SEQ_BITS     = 16;
    localparam int TAG_W        = $clog2(TAG_COUNT);
    localparam int FREE_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RANDOM_BEATS = 2000;
    localparam int DRAIN_LIMIT  = 2000;

    // One command beat, one field per port
    typedef struct packed {
        t_op                 op;
        logic [TAG_W-1:0]    src_a_tag;
        logic                src_a_present;
        logic                src_a_ready;
        logic [TAG_W-1:0]    src_b_tag;
        logic                src_b_present;
        logic                src_b_ready;
        logic [TAG_W-1:0]    dest_tag;
        logic [UNIT_W-1:0]   unit_type;
        logic [SEQ_BITS-1:0] age_seq;
        logic [UNIT_CNT-1:0] unit_free_mask;
    } t_iq_beat;

    // One result beat
    typedef struct packed {
        logic                issued;
        logic [TAG_W-1:0]    issued_dest;
        logic [UNIT_W-1:0]   issued_unit;
        logic [SEQ_BITS-1:0] issued_seq;
        logic                accepted;
        logic [FREE_W-1:0]   free_slots;
    } t_iq_result;

    // Shadow copy of one queue slot
    typedef struct packed {
        logic [TAG_W-1:0]    tag_a;
        logic [TAG_W-1:0]    tag_b;
        logic                rdy_a;
        logic                rdy_b;
        logic [TAG_W-1:0]    dest;
        logic [UNIT_W-1:0]   unit;
        logic [SEQ_BITS-1:0] seq;
    } t_slot;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_op = '0;
    logic [TAG_W-1:0]      i_src_a_tag = '0;
    logic                  i_src_a_present = 1'b0;
    logic                  i_src_a_ready = 1'b0;
    logic [TAG_W-1:0]      i_src_b_tag = '0;
    logic                  i_src_b_present = 1'b0;
    logic                  i_src_b_ready = 1'b0;
    logic [TAG_W-1:0]      i_dest_tag = '0;
    logic [UNIT_W-1:0]     i_unit_type = '0;
    logic [SEQ_BITS-1:0]   i_age_seq = '0;
    logic [UNIT_CNT-1:0]   i_unit_free_mask = '0;
    logic                  o_strobe;
    logic                  o_issued;
    logic [TAG_W-1:0]      o_issued_dest;
    logic [UNIT_W-1:0]     o_issued_unit;
    logic [SEQ_BITS-1:0]   o_issued_seq;
    logic                  o_accepted;
    logic [FREE_W-1:0]     o_free_slots;

    // Shadow queue state and the results still owed by the block
    logic                slot_valid [QUEUE_DEPTH];
    t_slot               slot_data [QUEUE_DEPTH];
    t_iq_result          owed_results [$];
    logic [SEQ_BITS-1:0] program_seq = 16'd1000;

    int error_count = 0;
    int n_dispatch = 0;
    int n_rejected = 0;
    int n_wakeup = 0;
    int n_select = 0;
    int n_issued = 0;
    int n_unused = 0;

    issue_queue_wakeup_select #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_COUNT   (TAG_COUNT),
        .SEQ_BITS    (SEQ_BITS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_src_a_tag      (i_src_a_tag),
        .i_src_a_present  (i_src_a_present),
        .i_src_a_ready    (i_src_a_ready),
        .i_src_b_tag      (i_src_b_tag),
        .i_src_b_present  (i_src_b_present),
        .i_src_b_ready    (i_src_b_ready),
        .i_dest_tag       (i_dest_tag),
        .i_unit_type      (i_unit_type),
        .i_age_seq        (i_age_seq),
        .i_unit_free_mask (i_unit_free_mask),
        .o_strobe         (o_strobe),
        .o_issued         (o_issued),
        .o_issued_dest    (o_issued_dest),
        .o_issued_unit    (o_issued_unit),
        .o_issued_seq     (o_issued_seq),
        .o_accepted       (o_accepted),
        .o_free_slots     (o_free_slots)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            slot_valid[k] = 1'b0;
            slot_data[k]  = '0;
        end
    end

    function automatic int free_count();
        int n;
        n = 0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (!slot_valid[k]) n++;
        end
        return n;
    endfunction

    // Apply one beat to the shadow queue and return the result it owes
    function automatic t_iq_result issue_queue_step(t_iq_beat b);
        t_iq_result r;
        int slot;
        int pick;
        r = '0;
        slot = -1;
        pick = -1;
        case (b.op)
            OP_DISPATCH: begin
                for (int k = 0; k < QUEUE_DEPTH; k++) begin
                    if (!slot_valid[k] && slot < 0) slot = k;
                end
                if (slot >= 0) begin
                    slot_data[slot].tag_a = b.src_a_tag;
                    slot_data[slot].rdy_a = !b.src_a_present || b.src_a_ready;
                    slot_data[slot].tag_b = b.src_b_tag;
                    slot_data[slot].rdy_b = !b.src_b_present || b.src_b_ready;
                    slot_data[slot].dest  = b.dest_tag;
                    slot_data[slot].unit  = b.unit_type;
                    slot_data[slot].seq   = b.age_seq;
                    slot_valid[slot] = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            OP_WAKEUP: begin
                for (int k = 0; k < QUEUE_DEPTH; k++) begin
                    if (slot_valid[k]) begin
                        if (slot_data[k].tag_a == b.dest_tag) slot_data[k].rdy_a = 1'b1;
                        if (slot_data[k].tag_b == b.dest_tag) slot_data[k].rdy_b = 1'b1;
                    end
                end
            end
            OP_SELECT: begin
                // Oldest ready entry; ties go to the lower slot
                for (int k = 0; k < QUEUE_DEPTH; k++) begin
                    if (slot_valid[k] && slot_data[k].rdy_a && slot_data[k].rdy_b &&
                        (pick < 0 || slot_data[k].seq < slot_data[pick].seq)) begin
                        pick = k;
                    end
                end
                // Issue only if its unit class is free; never fall back to a younger entry
                if (pick >= 0 && slot_data[pick].unit < UNIT_CNT &&
                    b.unit_free_mask[slot_data[pick].unit]) begin
                    slot_valid[pick] = 1'b0;
                    r.issued      = 1'b1;
                    r.issued_dest = slot_data[pick].dest;
                    r.issued_unit = slot_data[pick].unit;
                    r.issued_seq  = slot_data[pick].seq;
                end
            end
            default: ;
        endcase
        r.free_slots = FREE_W'(free_count());
        return r;
    endfunction

    function automatic t_iq_beat blank_beat(t_op op);
        t_iq_beat b;
        b = '0;
        b.op = op;
        return b;
    endfunction

    function automatic t_iq_beat dispatch_beat(
        logic [TAG_W-1:0] a_tag, logic a_present, logic a_ready,
        logic [TAG_W-1:0] b_tag, logic b_present, logic b_ready,
        logic [TAG_W-1:0] dest, logic [UNIT_W-1:0] unit, logic [SEQ_BITS-1:0] seq);
        t_iq_beat b;
        b = blank_beat(OP_DISPATCH);
        b.src_a_tag     = a_tag;
        b.src_a_present = a_present;
        b.src_a_ready   = a_ready;
        b.src_b_tag     = b_tag;
        b.src_b_present = b_present;
        b.src_b_ready   = b_ready;
        b.dest_tag      = dest;
        b.unit_type     = unit;
        b.age_seq       = seq;
        return b;
    endfunction

    function automatic t_iq_beat wakeup_beat(logic [TAG_W-1:0] tag);
        t_iq_beat b;
        b = blank_beat(OP_WAKEUP);
        b.dest_tag = tag;
        return b;
    endfunction

    function automatic t_iq_beat select_beat(logic [UNIT_CNT-1:0] mask);
        t_iq_beat b;
        b = blank_beat(OP_SELECT);
        b.unit_free_mask = mask;
        return b;
    endfunction

    // Random beat; wakeups mostly target sources still waiting in the queue
    function automatic t_iq_beat random_beat();
        t_iq_beat b;
        int roll;
        logic [TAG_W-1:0] waiting [$];
        b.op             = OP_NONE;
        b.src_a_tag      = TAG_W'($urandom_range(0, TAG_COUNT - 1));
        b.src_a_present  = $urandom_range(0, 4) != 0;
        b.src_a_ready    = $urandom_range(0, 2) == 0;
        b.src_b_tag      = TAG_W'($urandom_range(0, TAG_COUNT - 1));
        b.src_b_present  = $urandom_range(0, 4) != 0;
        b.src_b_ready    = $urandom_range(0, 2) == 0;
        b.dest_tag       = TAG_W'($urandom_range(0, TAG_COUNT - 1));
        b.unit_type      = UNIT_W'($urandom_range(0, UNIT_CNT - 1));
        b.age_seq        = SEQ_BITS'($urandom);
        b.unit_free_mask = UNIT_CNT'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            b.op = OP_DISPATCH;
            if ($urandom_range(0, 4) != 0) begin
                b.age_seq = program_seq;
                program_seq = program_seq + SEQ_BITS'($urandom_range(1, 3));
            end
        end else if (roll < 70) begin
            b.op = OP_WAKEUP;
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                if (slot_valid[k] && !slot_data[k].rdy_a) waiting.push_back(slot_data[k].tag_a);
                if (slot_valid[k] && !slot_data[k].rdy_b) waiting.push_back(slot_data[k].tag_b);
            end
            if (waiting.size() > 0 && $urandom_range(0, 9) < 7) begin
                b.dest_tag = waiting[$urandom_range(0, waiting.size() - 1)];
            end
        end else if (roll < 95) begin
            b.op = OP_SELECT;
            if ($urandom_range(0, 1) != 0) b.unit_free_mask = '1;
        end
        return b;
    endfunction

    // Drive one beat, hold it until taken, then log what it owes
    task automatic send_beat(t_iq_beat b);
        t_iq_result r;
        start            <= 1'b1;
        i_op             <= b.op;
        i_src_a_tag      <= b.src_a_tag;
        i_src_a_present  <= b.src_a_present;
        i_src_a_ready    <= b.src_a_ready;
        i_src_b_tag      <= b.src_b_tag;
        i_src_b_present  <= b.src_b_present;
        i_src_b_ready    <= b.src_b_ready;
        i_dest_tag       <= b.dest_tag;
        i_unit_type      <= b.unit_type;
        i_age_seq        <= b.age_seq;
        i_unit_free_mask <= b.unit_free_mask;
        do @(posedge i_clk); while (busy);
        r = issue_queue_step(b);
        owed_results.push_back(r);
        case (b.op)
            OP_DISPATCH: begin
                n_dispatch++;
                if (!r.accepted) n_rejected++;
            end
            OP_WAKEUP: n_wakeup++;
            OP_SELECT: begin
                n_select++;
                if (r.issued) n_issued++;
            end
            default: n_unused++;
        endcase
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic compare_field(string label, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            error_count++;
        end
    endtask

    // Match every strobed result against the oldest owed one
    always @(posedge i_clk) begin : check_results
        t_iq_result want;
        if (i_rst_n && o_strobe) begin
            if (owed_results.size() == 0) begin
                $display("%0t: result with nothing owed, expected none, actual issued=%0d accepted=%0d free=%0d",
                         $time, o_issued, o_accepted, o_free_slots);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                compare_field("issued", 32'(want.issued), 32'(o_issued));
                compare_field("issued_dest", 32'(want.issued_dest), 32'(o_issued_dest));
                compare_field("issued_unit", 32'(want.issued_unit), 32'(o_issued_unit));
                compare_field("issued_seq", 32'(want.issued_seq), 32'(o_issued_seq));
                compare_field("accepted", 32'(want.accepted), 32'(o_accepted));
                compare_field("free_slots", 32'(want.free_slots), 32'(o_free_slots));
            end
        end
    end

    // Empty queue, unused op, fill to full, reject, wake and pick among ties
    task automatic test_fill_and_wake();
        send_beat(select_beat('1));
        send_beat(t_iq_beat'({OP_NONE, {($bits(t_iq_beat) - OP_W){1'b1}}}));
        send_beat(wakeup_beat(6'd63));
        // Absent sources with ready low still count as ready
        send_beat(dispatch_beat(6'd63, 1'b0, 1'b0, 6'd63, 1'b0, 1'b0, 6'd63, 2'd0, 16'hFFFE));
        send_beat(dispatch_beat(6'd0, 1'b1, 1'b0, 6'd63, 1'b1, 1'b0, 6'd0, 2'd1, 16'h0000));
        send_beat(dispatch_beat(6'd5, 1'b1, 1'b1, 6'd9, 1'b0, 1'b1, 6'd21, 2'd2, 16'd10));
        // Same age for a run of entries so the lowest slot must win
        for (int k = 3; k < QUEUE_DEPTH - 2; k++) begin
            send_beat(dispatch_beat(6'd7, 1'b1, 1'b0, TAG_W'(k), 1'b1, 1'b1,
                                    TAG_W'(k + 30), UNIT_W'(k % UNIT_CNT), 16'd20));
        end
        send_beat(dispatch_beat(6'd7, 1'b0, 1'b1, 6'd7, 1'b1, 1'b0, 6'd42, 2'd1, 16'd20));
        // Unit class 3 in the last slot, youngest possible age
        send_beat(dispatch_beat(6'd1, 1'b0, 1'b0, 6'd2, 1'b0, 1'b0, 6'd33, 2'd3, 16'hFFFF));
        send_beat(dispatch_beat(6'd11, 1'b1, 1'b0, 6'd12, 1'b1, 1'b0, 6'd13, 2'd0, 16'd1));
        send_beat(select_beat('0));
        send_beat(select_beat(3'b100));
        send_beat(wakeup_beat(6'd0));
        send_beat(wakeup_beat(6'd63));
        send_beat(select_beat('1));
        send_beat(wakeup_beat(6'd7));
        send_beat(select_beat('1));
    endtask

    // Issue everything left until the unit class 3 entry blocks select
    task automatic test_drain_to_blocked();
        while (free_count() < QUEUE_DEPTH - 1) begin
            send_beat(select_beat('1));
        end
        send_beat(select_beat('1));
    endtask

    // Random traffic, idling in bursts except in the last quarter
    task automatic test_random_traffic();
        t_iq_beat b;
        int sent;
        bit idling;
        sent = 0;
        idling = 1'b0;
        while (sent < RANDOM_BEATS) begin
            if (sent % 100 == 0) begin
                idling = (sent < RANDOM_BEATS * 3 / 4) && ($urandom_range(0, 2) != 0);
            end
            b = random_beat();
            send_beat(b);
            if (b.op != OP_NONE) sent++;
            if (idling && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 10));
        end
    endtask

    task automatic wait_for_drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (owed_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (QUEUE_DEPTH + 4) @(posedge i_clk);
        if (owed_results.size() != 0) begin
            $display("%0t: results never arrived, expected %0d more, actual 0",
                     $time, owed_results.size());
            error_count++;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_fill_and_wake();
        test_drain_to_blocked();
        test_random_traffic();
        wait_for_drain();
        $display("Sent %0d dispatches (%0d refused on a full queue), %0d wakeups,",
                 n_dispatch, n_rejected, n_wakeup);
        $display("%0d selects (%0d issued) and %0d beats with the unused op code.",
                 n_select, n_issued, n_unused);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
